// ===== rtl/core/plis_pkg.sv =====
// ----------------------------------------------------------------------------
// plis_pkg
// Shared types and constants for the playlist line index and shuffle table.
// ----------------------------------------------------------------------------
`default_nettype none

package plis_pkg;

  // Item operation codes as they arrive on the input channel
  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_BYTE    = 2'd1;
  localparam logic [1:0] OP_SHUFFLE = 2'd2;
  localparam logic [1:0] OP_ADVANCE = 2'd3;

  // Text characters of interest
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_HASH = 8'h23;

  // Field widths fixed by the interface
  localparam int unsigned OFFSET_W = 32;
  localparam int unsigned COUNT_W  = 11;
  localparam int unsigned RAND_W   = 31;
  localparam int unsigned STEPS_W  = 10;
  localparam int unsigned DVD_W    = 32;

  // Depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_BYTE,
    CMD_SHUFFLE,
    CMD_ADVANCE
  } cmd_kind_t;

  typedef enum logic [1:0] {
    BC_BREAK,
    BC_HASH,
    BC_OTHER
  } byte_cls_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    BS_IDLE,
    BS_DIV_SHUF,
    BS_RD_CAND,
    BS_RD_SWAP,
    BS_WR_CAND,
    BS_WR_SWAP,
    BS_DIV_ADV,
    BS_RD_ADV,
    BS_OUT_ADV
  } back_state_t;

  // Classified item as it travels through the queue
  typedef struct packed {
    cmd_kind_t           kind;
    byte_cls_t           cls;
    logic [RAND_W-1:0]   random_word;
    logic [STEPS_W-1:0]  steps;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/playlist_line_index_shuffle_table_unit.sv =====
// ----------------------------------------------------------------------------
// playlist_line_index_shuffle_table_unit
// Clear and byte items, shuffle items with no swap left and advance items on
// an empty table give their result as soon as they leave the queue; a shuffle
// step with a swap left and an advance on a nonempty table first run the
// 32-step serial remainder unit, then the table's write and registered read ports.
// Throughput: one clear or byte item per cycle; the 2-entry queue absorbs
// items while a shuffle or advance runs. Results cannot be stalled.
// Reset clears control state only; table entries are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module playlist_line_index_shuffle_table_unit #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    in_op,
  input  wire logic [7:0]                    in_text_byte,
  input  wire logic [plis_pkg::RAND_W-1:0]   in_random_word,
  input  wire logic [plis_pkg::STEPS_W-1:0]  in_steps,
  output logic                               out_valid,
  output logic [plis_pkg::OFFSET_W-1:0]      out_line_offset,
  output logic [plis_pkg::COUNT_W-1:0]       out_entry_count,
  output logic                               out_recorded,
  output logic                               out_shuffle_finished,
  output logic [1:0]                         out_status
);

  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  logic                        push;
  plis_pkg::cmd_t              push_cmd;
  logic                        q_full;
  logic                        q_empty;
  logic                        q_pop;
  plis_pkg::cmd_t              q_head;
  logic                        div_start;
  logic [plis_pkg::DVD_W-1:0]  div_dividend;
  logic [CW-1:0]               div_divisor;
  logic                        div_done;
  logic [CW-1:0]               div_rem;

  assign busy = q_full;

  plis_front u_front (
    .start          (start),
    .q_full         (q_full),
    .in_op          (in_op),
    .in_text_byte   (in_text_byte),
    .in_random_word (in_random_word),
    .in_steps       (in_steps),
    .push           (push),
    .cmd            (push_cmd)
  );

  plis_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  plis_div #(
    .DIVISOR_W (CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .rem      (div_rem)
  );

  plis_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_empty              (q_empty),
    .q_head               (q_head),
    .q_pop                (q_pop),
    .div_start            (div_start),
    .div_dividend         (div_dividend),
    .div_divisor          (div_divisor),
    .div_done             (div_done),
    .div_rem              (div_rem),
    .out_valid            (out_valid),
    .out_line_offset      (out_line_offset),
    .out_entry_count      (out_entry_count),
    .out_recorded         (out_recorded),
    .out_shuffle_finished (out_shuffle_finished),
    .out_status           (out_status)
  );

endmodule

`default_nettype wire

// ===== rtl/core/plis_front.sv =====
// ----------------------------------------------------------------------------
// plis_front
// Accepts items from the command port and classifies them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module plis_front (
  input  wire logic                          start,
  input  wire logic                          q_full,
  input  wire logic [1:0]                    in_op,
  input  wire logic [7:0]                    in_text_byte,
  input  wire logic [plis_pkg::RAND_W-1:0]   in_random_word,
  input  wire logic [plis_pkg::STEPS_W-1:0]  in_steps,
  output logic                               push,
  output plis_pkg::cmd_t                     cmd
);

  // Accept an item whenever the queue has room
  assign push = start && !q_full;

  // Decode the operation and the character class of the byte
  always_comb begin
    cmd.random_word = in_random_word;
    cmd.steps       = in_steps;
    unique case (in_op)
      plis_pkg::OP_CLEAR:   cmd.kind = plis_pkg::CMD_CLEAR;
      plis_pkg::OP_BYTE:    cmd.kind = plis_pkg::CMD_BYTE;
      plis_pkg::OP_SHUFFLE: cmd.kind = plis_pkg::CMD_SHUFFLE;
      plis_pkg::OP_ADVANCE: cmd.kind = plis_pkg::CMD_ADVANCE;
      default:              cmd.kind = plis_pkg::CMD_CLEAR;
    endcase
    unique case (in_text_byte) inside
      plis_pkg::CH_LF, plis_pkg::CH_CR: cmd.cls = plis_pkg::BC_BREAK;
      plis_pkg::CH_HASH:                cmd.cls = plis_pkg::BC_HASH;
      default:                          cmd.cls = plis_pkg::BC_OTHER;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/plis_queue.sv =====
// ----------------------------------------------------------------------------
// plis_queue
// Short in-order queue of classified items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module plis_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  plis_pkg::cmd_t        push_data,
  output logic                  full,
  input  wire logic             pop,
  output plis_pkg::cmd_t        head,
  output logic                  empty
);

  localparam int unsigned PTR_W = $clog2(plis_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(plis_pkg::QUEUE_DEPTH + 1);

  plis_pkg::cmd_t   slot_r [plis_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNT_W'(plis_pkg::QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = slot_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(plis_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(plis_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/plis_div.sv =====
// ----------------------------------------------------------------------------
// plis_div
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module plis_div #(
  parameter int unsigned DIVISOR_W = 11
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [plis_pkg::DVD_W-1:0]  dividend,
  input  wire logic [DIVISOR_W-1:0]        divisor,
  output logic                             done,
  output logic [DIVISOR_W-1:0]             rem
);

  localparam int unsigned STEP_W = $clog2(plis_pkg::DVD_W + 1);

  logic [plis_pkg::DVD_W-1:0] dvd_r, dvd_nxt;
  logic [DIVISOR_W-1:0]       div_r, div_nxt;
  logic [DIVISOR_W-1:0]       rem_r, rem_nxt;
  logic [STEP_W-1:0]          step_r, step_nxt;
  logic                       done_r, done_nxt;
  logic [DIVISOR_W:0]         trial;
  logic [DIVISOR_W:0]         diff;

  assign trial = {rem_r, dvd_r[plis_pkg::DVD_W-1]};
  assign diff  = trial - {1'b0, div_r};

  // Shift in one dividend bit and subtract when it fits
  always_comb begin
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = dividend;
      div_nxt  = divisor;
      rem_nxt  = '0;
      step_nxt = STEP_W'(plis_pkg::DVD_W);
    end else if (step_r != '0) begin
      dvd_nxt  = {dvd_r[plis_pkg::DVD_W-2:0], 1'b0};
      rem_nxt  = (trial >= {1'b0, div_r}) ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      step_nxt = step_r - 1'b1;
      done_nxt = (step_r == STEP_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

// ===== rtl/core/plis_back.sv =====
// ----------------------------------------------------------------------------
// plis_back
// Executes classified items against the offset table and drives results.
// ----------------------------------------------------------------------------
`default_nettype none

module plis_back #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                q_empty,
  input  plis_pkg::cmd_t                           q_head,
  output logic                                     q_pop,
  output logic                                     div_start,
  output logic [plis_pkg::DVD_W-1:0]               div_dividend,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]         div_divisor,
  input  wire logic                                div_done,
  input  wire logic [$clog2(TABLE_DEPTH+1)-1:0]    div_rem,
  output logic                                     out_valid,
  output logic [plis_pkg::OFFSET_W-1:0]            out_line_offset,
  output logic [plis_pkg::COUNT_W-1:0]             out_entry_count,
  output logic                                     out_recorded,
  output logic                                     out_shuffle_finished,
  output logic [1:0]                               out_status
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned OW = plis_pkg::OFFSET_W;

  plis_pkg::back_state_t state_r, state_nxt;

  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] cur_r, cur_nxt;
  logic [AW-1:0] swap_r, swap_nxt;
  logic [AW-1:0] cand_r, cand_nxt;
  logic          at_line_r, at_line_nxt;
  logic [OW-1:0] byte_pos_r, byte_pos_nxt;
  logic [OW-1:0] hold_r, hold_nxt;

  logic                           out_valid_r, out_valid_nxt;
  logic [OW-1:0]                  out_offset_r, out_offset_nxt;
  logic [plis_pkg::COUNT_W-1:0]   out_count_r, out_count_nxt;
  logic                           out_rec_r, out_rec_nxt;
  logic                           out_fin_r, out_fin_nxt;
  plis_pkg::status_t              out_status_r, out_status_nxt;

  logic [OW-1:0] mem [TABLE_DEPTH];
  logic [OW-1:0] rd_data_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [OW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;

  logic          table_full;
  logic          byte_rec;
  logic [CW-1:0] count_pl1;

  assign table_full = (count_r == CW'(TABLE_DEPTH));
  assign byte_rec   = at_line_r && (q_head.cls == plis_pkg::BC_OTHER);
  assign count_pl1  = count_r + 1'b1;

  // Divider operands are built from the item at the queue head and the table state
  assign div_dividend = (q_head.kind == plis_pkg::CMD_SHUFFLE)
                        ? plis_pkg::DVD_W'(q_head.random_word)
                        : plis_pkg::DVD_W'(cur_r) + plis_pkg::DVD_W'(q_head.steps);
  assign div_divisor  = (q_head.kind == plis_pkg::CMD_SHUFFLE)
                        ? CW'(swap_r) + CW'(1) : count_r;

  // Sequence each item and build its result
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    cur_nxt        = cur_r;
    swap_nxt       = swap_r;
    cand_nxt       = cand_r;
    at_line_nxt    = at_line_r;
    byte_pos_nxt   = byte_pos_r;
    hold_nxt       = hold_r;
    out_valid_nxt  = 1'b0;
    out_offset_nxt = out_offset_r;
    out_count_nxt  = out_count_r;
    out_rec_nxt    = out_rec_r;
    out_fin_nxt    = out_fin_r;
    out_status_nxt = out_status_r;
    q_pop          = 1'b0;
    div_start      = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = cand_r;
    mem_wdata      = rd_data_r;
    mem_raddr      = cand_r;

    unique case (state_r)
      plis_pkg::BS_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          unique case (q_head.kind)
            plis_pkg::CMD_CLEAR: begin
              count_nxt      = '0;
              cur_nxt        = '0;
              swap_nxt       = '0;
              at_line_nxt    = 1'b1;
              byte_pos_nxt   = '0;
              out_valid_nxt  = 1'b1;
              out_offset_nxt = '0;
              out_count_nxt  = '0;
              out_rec_nxt    = 1'b0;
              out_fin_nxt    = 1'b1;
              out_status_nxt = plis_pkg::ST_OK;
            end
            plis_pkg::CMD_BYTE: begin
              out_valid_nxt = 1'b1;
              if (table_full) begin
                out_offset_nxt = '0;
                out_count_nxt  = plis_pkg::COUNT_W'(count_r);
                out_rec_nxt    = 1'b0;
                out_fin_nxt    = (swap_r == '0);
                out_status_nxt = plis_pkg::ST_FULL;
              end else begin
                if (q_head.cls == plis_pkg::BC_BREAK) begin
                  at_line_nxt = 1'b1;
                end else if (at_line_r) begin
                  at_line_nxt = 1'b0;
                end
                if (byte_rec) begin
                  mem_we    = 1'b1;
                  mem_waddr = count_r[AW-1:0];
                  mem_wdata = byte_pos_r;
                  swap_nxt  = count_r[AW-1:0];
                  count_nxt = count_pl1;
                end
                if (byte_pos_r != '1) begin
                  byte_pos_nxt = byte_pos_r + 1'b1;
                end
                out_offset_nxt = byte_rec ? byte_pos_r : '0;
                out_count_nxt  = plis_pkg::COUNT_W'(byte_rec ? count_pl1 : count_r);
                out_rec_nxt    = byte_rec;
                out_fin_nxt    = byte_rec ? (count_r == '0) : (swap_r == '0);
                out_status_nxt = plis_pkg::ST_OK;
              end
            end
            plis_pkg::CMD_SHUFFLE: begin
              if (swap_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_offset_nxt = '0;
                out_count_nxt  = plis_pkg::COUNT_W'(count_r);
                out_rec_nxt    = 1'b0;
                out_fin_nxt    = 1'b1;
                out_status_nxt = (count_r == '0) ? plis_pkg::ST_EMPTY : plis_pkg::ST_OK;
              end else begin
                div_start = 1'b1;
                state_nxt = plis_pkg::BS_DIV_SHUF;
              end
            end
            plis_pkg::CMD_ADVANCE: begin
              if (count_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_offset_nxt = '0;
                out_count_nxt  = '0;
                out_rec_nxt    = 1'b0;
                out_fin_nxt    = (swap_r == '0);
                out_status_nxt = plis_pkg::ST_EMPTY;
              end else begin
                div_start = 1'b1;
                state_nxt = plis_pkg::BS_DIV_ADV;
              end
            end
            default: ;
          endcase
        end
      end
      // Swap candidate is the random word modulo the live range
      plis_pkg::BS_DIV_SHUF: begin
        if (div_done) begin
          cand_nxt  = div_rem[AW-1:0];
          state_nxt = plis_pkg::BS_RD_CAND;
        end
      end
      plis_pkg::BS_RD_CAND: begin
        mem_raddr = cand_r;
        state_nxt = plis_pkg::BS_RD_SWAP;
      end
      plis_pkg::BS_RD_SWAP: begin
        mem_raddr = swap_r;
        hold_nxt  = rd_data_r;
        state_nxt = plis_pkg::BS_WR_CAND;
      end
      plis_pkg::BS_WR_CAND: begin
        mem_we    = 1'b1;
        mem_waddr = cand_r;
        mem_wdata = rd_data_r;
        state_nxt = plis_pkg::BS_WR_SWAP;
      end
      plis_pkg::BS_WR_SWAP: begin
        mem_we         = 1'b1;
        mem_waddr      = swap_r;
        mem_wdata      = hold_r;
        swap_nxt       = swap_r - 1'b1;
        out_valid_nxt  = 1'b1;
        out_offset_nxt = '0;
        out_count_nxt  = plis_pkg::COUNT_W'(count_r);
        out_rec_nxt    = 1'b0;
        out_fin_nxt    = (swap_r == AW'(1));
        out_status_nxt = plis_pkg::ST_OK;
        state_nxt      = plis_pkg::BS_IDLE;
      end
      // New position is the advanced position modulo the entry count
      plis_pkg::BS_DIV_ADV: begin
        if (div_done) begin
          cur_nxt   = div_rem[AW-1:0];
          state_nxt = plis_pkg::BS_RD_ADV;
        end
      end
      plis_pkg::BS_RD_ADV: begin
        mem_raddr = cur_r;
        state_nxt = plis_pkg::BS_OUT_ADV;
      end
      plis_pkg::BS_OUT_ADV: begin
        out_valid_nxt  = 1'b1;
        out_offset_nxt = rd_data_r;
        out_count_nxt  = plis_pkg::COUNT_W'(count_r);
        out_rec_nxt    = 1'b0;
        out_fin_nxt    = (swap_r == '0);
        out_status_nxt = plis_pkg::ST_OK;
        state_nxt      = plis_pkg::BS_IDLE;
      end
      default: state_nxt = plis_pkg::BS_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= plis_pkg::BS_IDLE;
      count_r     <= '0;
      cur_r       <= '0;
      swap_r      <= '0;
      at_line_r   <= 1'b1;
      byte_pos_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cur_r       <= cur_nxt;
      swap_r      <= swap_nxt;
      at_line_r   <= at_line_nxt;
      byte_pos_r  <= byte_pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cand_r       <= cand_nxt;
    hold_r       <= hold_nxt;
    out_offset_r <= out_offset_nxt;
    out_count_r  <= out_count_nxt;
    out_rec_r    <= out_rec_nxt;
    out_fin_r    <= out_fin_nxt;
    out_status_r <= out_status_nxt;
  end

  // Offset table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  assign out_valid            = out_valid_r;
  assign out_line_offset      = out_offset_r;
  assign out_entry_count      = out_count_r;
  assign out_recorded         = out_rec_r;
  assign out_shuffle_finished = out_fin_r;
  assign out_status           = out_status_r;

endmodule

`default_nettype wire

// ===== rtl/core/plis_checker.sv =====
// ----------------------------------------------------------------------------
// plis_checker
// Port-level checks on results of the playlist line index unit.
// ----------------------------------------------------------------------------
`default_nettype none

module plis_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          busy,
  input wire logic                          out_valid,
  input wire logic [plis_pkg::OFFSET_W-1:0] out_line_offset,
  input wire logic [plis_pkg::COUNT_W-1:0]  out_entry_count,
  input wire logic                          out_recorded,
  input wire logic                          out_shuffle_finished,
  input wire logic [1:0]                    out_status
);

  // Reset drains the queue and drops any pending result
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_valid))
    else $error("busy or result strobe right after reset");

  // Status carries only defined codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == plis_pkg::ST_OK || out_status == plis_pkg::ST_FULL ||
                   out_status == plis_pkg::ST_EMPTY))
    else $error("undefined status code");

  // A recorded line start means a successful byte and a nonempty table
  a_record_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_recorded) |-> (out_status == plis_pkg::ST_OK && out_entry_count != '0))
    else $error("recorded entry with bad status or zero count");

  // An empty table reports no offset and no pending swaps
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == plis_pkg::ST_EMPTY) |->
      (out_entry_count == '0 && out_line_offset == '0 && out_shuffle_finished &&
       !out_recorded))
    else $error("empty status with nonzero result fields");

endmodule

bind playlist_line_index_shuffle_table_unit plis_checker u_plis_checker (.*);

`default_nettype wire

// ===== sim/playlist_line_index_shuffle_table_unit_test.sv =====
// ----------------------------------------------------------------------------
// playlist_line_index_shuffle_table_unit_test
// Drives clear, text byte, shuffle step and advance items into the line index
// table and checks every result against an in-bench copy of the table state:
// directed corner cases first, then random playlist text mixed with shuffle
// runs and advances, then a fill to full capacity.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module playlist_line_index_shuffle_table_unit_test;

  localparam int unsigned TABLE_DEPTH    = 1024;
  localparam int unsigned RANDOM_ITEMS   = 600;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 48;

  typedef struct {
    logic [plis_pkg::OFFSET_W-1:0] line_offset;
    logic [plis_pkg::COUNT_W-1:0]  entry_count;
    logic                          recorded;
    logic                          shuffle_finished;
    plis_pkg::status_t             status;
  } line_result_t;

  // Shadow copy of the line table; predicts one result per item
  class line_table_scoreboard;
    logic [plis_pkg::OFFSET_W-1:0] offsets [TABLE_DEPTH];
    int unsigned                   entries;
    int unsigned                   cur_pos;
    logic                          at_start;
    logic [31:0]                   byte_pos;
    int unsigned                   swap_pos;
    line_result_t                  pending_results [$];
    int unsigned                   mismatches;

    function new();
      clear_state();
      mismatches = 0;
    endfunction

    function void clear_state();
      entries  = 0;
      cur_pos  = 0;
      at_start = 1'b1;
      byte_pos = '0;
      swap_pos = 0;
    endfunction

    // Apply one accepted item and queue the result it should produce
    function void note_item(logic [1:0] op, logic [7:0] text_byte,
                            logic [plis_pkg::RAND_W-1:0] random_word,
                            logic [plis_pkg::STEPS_W-1:0] steps);
      line_result_t                  res;
      int unsigned                   cand;
      logic [plis_pkg::OFFSET_W-1:0] held;
      res.line_offset = '0;
      res.recorded    = 1'b0;
      res.status      = plis_pkg::ST_OK;
      case (op)
        plis_pkg::OP_CLEAR: begin
          clear_state();
        end
        plis_pkg::OP_BYTE: begin
          if (entries >= TABLE_DEPTH) begin
            res.status = plis_pkg::ST_FULL;
          end else begin
            if (text_byte == plis_pkg::CH_LF || text_byte == plis_pkg::CH_CR) begin
              at_start = 1'b1;
            end else if (at_start && text_byte == plis_pkg::CH_HASH) begin
              at_start = 1'b0;
            end else if (at_start) begin
              offsets[entries] = byte_pos;
              res.line_offset  = byte_pos;
              res.recorded     = 1'b1;
              swap_pos         = entries;
              entries++;
              at_start = 1'b0;
            end
            if (byte_pos != 32'hFFFF_FFFF) byte_pos++;
          end
        end
        plis_pkg::OP_SHUFFLE: begin
          if (entries == 0) res.status = plis_pkg::ST_EMPTY;
          if (swap_pos != 0 && swap_pos < entries) begin
            cand = random_word % (swap_pos + 1);
            held = offsets[cand];
            offsets[cand] = offsets[swap_pos];
            offsets[swap_pos] = held;
            swap_pos--;
          end else if (swap_pos >= entries) begin
            swap_pos = 0;
          end
        end
        default: begin
          if (entries == 0) begin
            res.status = plis_pkg::ST_EMPTY;
          end else begin
            cur_pos = (cur_pos + steps) % entries;
            res.line_offset = offsets[cur_pos];
          end
        end
      endcase
      res.entry_count      = entries[plis_pkg::COUNT_W-1:0];
      res.shuffle_finished = (swap_pos == 0);
      pending_results.push_back(res);
    endfunction

    // Compare one result, field by field, with the oldest prediction
    function void check_result(logic [plis_pkg::OFFSET_W-1:0] line_offset,
                               logic [plis_pkg::COUNT_W-1:0] entry_count,
                               logic recorded, logic shuffle_finished,
                               logic [1:0] status);
      line_result_t want;
      if (pending_results.size() == 0) begin
        $error("result with no item outstanding: line_offset %0h", line_offset);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      if (line_offset !== want.line_offset) begin
        $error("line_offset: expected %0h, actual %0h", want.line_offset, line_offset);
        mismatches++;
      end
      if (entry_count !== want.entry_count) begin
        $error("entry_count: expected %0d, actual %0d", want.entry_count, entry_count);
        mismatches++;
      end
      if (recorded !== want.recorded) begin
        $error("recorded: expected %0b, actual %0b", want.recorded, recorded);
        mismatches++;
      end
      if (shuffle_finished !== want.shuffle_finished) begin
        $error("shuffle_finished: expected %0b, actual %0b",
               want.shuffle_finished, shuffle_finished);
        mismatches++;
      end
      if (status !== 2'(want.status)) begin
        $error("status: expected %0d, actual %0d", 2'(want.status), status);
        mismatches++;
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic [1:0]                    in_op = plis_pkg::OP_CLEAR;
  logic [7:0]                    in_text_byte = '0;
  logic [plis_pkg::RAND_W-1:0]   in_random_word = '0;
  logic [plis_pkg::STEPS_W-1:0]  in_steps = '0;
  logic                          out_valid;
  logic [plis_pkg::OFFSET_W-1:0] out_line_offset;
  logic [plis_pkg::COUNT_W-1:0]  out_entry_count;
  logic                          out_recorded;
  logic                          out_shuffle_finished;
  logic [1:0]                    out_status;

  line_table_scoreboard sb = new();
  int unsigned          quiet_cycles = 0;
  bit                   steady_sender = 1'b0;

  playlist_line_index_shuffle_table_unit #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_op                (in_op),
    .in_text_byte         (in_text_byte),
    .in_random_word       (in_random_word),
    .in_steps             (in_steps),
    .out_valid            (out_valid),
    .out_line_offset      (out_line_offset),
    .out_entry_count      (out_entry_count),
    .out_recorded         (out_recorded),
    .out_shuffle_finished (out_shuffle_finished),
    .out_status           (out_status)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Check results and note accepted items on the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid)
        sb.check_result(out_line_offset, out_entry_count, out_recorded,
                        out_shuffle_finished, out_status);
      if (start && !busy)
        sb.note_item(in_op, in_text_byte, in_random_word, in_steps);
    end
  end

  // Stop the run if nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Present one item after a random gap and hold it until accepted
  task automatic send_item(input logic [1:0] op, input logic [7:0] text_byte,
                           input logic [plis_pkg::RAND_W-1:0] random_word,
                           input logic [plis_pkg::STEPS_W-1:0] steps);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) steady_sender = ($urandom_range(0, 2) == 0);
    gap = steady_sender ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_op          <= op;
    in_text_byte   <= text_byte;
    in_random_word <= random_word;
    in_steps       <= steps;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_byte(input logic [7:0] text_byte);
    send_item(plis_pkg::OP_BYTE, text_byte, plis_pkg::RAND_W'($urandom),
              plis_pkg::STEPS_W'($urandom));
  endtask

  task automatic send_shuffle(input logic [plis_pkg::RAND_W-1:0] random_word);
    send_item(plis_pkg::OP_SHUFFLE, 8'($urandom), random_word,
              plis_pkg::STEPS_W'($urandom));
  endtask

  task automatic send_advance(input logic [plis_pkg::STEPS_W-1:0] steps);
    send_item(plis_pkg::OP_ADVANCE, 8'($urandom), plis_pkg::RAND_W'($urandom), steps);
  endtask

  task automatic send_clear();
    send_item(plis_pkg::OP_CLEAR, 8'($urandom), plis_pkg::RAND_W'($urandom),
              plis_pkg::STEPS_W'($urandom));
  endtask

  // Any byte that is neither a line break nor a comment mark
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom);
    while (b == plis_pkg::CH_LF || b == plis_pkg::CH_CR || b == plis_pkg::CH_HASH)
      b = 8'($urandom);
    return b;
  endfunction

  // Playlist-like text: frequent line breaks and comment marks
  function automatic logic [7:0] text_byte_pick();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 18) return plis_pkg::CH_LF;
    if (roll < 24) return plis_pkg::CH_CR;
    if (roll < 32) return plis_pkg::CH_HASH;
    return 8'($urandom);
  endfunction

  initial begin
    int unsigned sent;
    int unsigned run;
    int unsigned roll;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Empty table: advance and shuffle both report empty
    send_advance(10'h3FF);
    send_shuffle(31'h7FFF_FFFF);
    // First line recorded at offset zero; one entry leaves nothing to swap
    send_byte("A");
    send_shuffle(31'h1234_5678);
    // Comment line, carriage return, extreme byte values as line starts
    send_byte(plis_pkg::CH_LF);
    send_byte(plis_pkg::CH_HASH);
    send_byte("x");
    send_byte(plis_pkg::CH_CR);
    send_byte(8'h00);
    send_byte(plis_pkg::CH_LF);
    send_byte(8'hFF);
    send_byte(plis_pkg::CH_CR);
    send_byte(plis_pkg::CH_LF);
    send_byte("b");
    // Full shuffle countdown over four entries with extreme words
    send_shuffle(31'h7FFF_FFFF);
    send_shuffle(31'h0000_0000);
    send_shuffle(31'h2AAA_AAAA);
    send_shuffle(31'h5555_5555);
    // Advance by zero, by the maximum and by a mixed pattern
    send_advance(10'h000);
    send_advance(10'h3FF);
    send_advance(10'h155);
    send_clear();
    send_advance(10'h2AA);

    // Random text mixed with shuffle runs, advances and rare clears
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        send_byte(text_byte_pick());
        sent++;
      end else if (roll < 76) begin
        run = $urandom_range(1, 12);
        repeat (run) send_shuffle(plis_pkg::RAND_W'($urandom));
        sent += run;
      end else if (roll < 97) begin
        send_advance($urandom_range(0, 3) == 0
                     ? plis_pkg::STEPS_W'($urandom_range(0, 3))
                     : plis_pkg::STEPS_W'($urandom));
        sent++;
      end else begin
        send_clear();
        sent++;
      end
    end

    // Fill the table to capacity with one-byte lines
    send_clear();
    repeat (TABLE_DEPTH) begin
      send_byte(plain_byte());
      send_byte(plis_pkg::CH_LF);
    end
    // Full table: bytes are ignored, shuffles and advances still work
    send_byte(plain_byte());
    send_byte(plis_pkg::CH_HASH);
    send_byte(plis_pkg::CH_LF);
    send_byte(plis_pkg::CH_CR);
    repeat (12) begin
      send_shuffle(plis_pkg::RAND_W'($urandom));
      send_advance(plis_pkg::STEPS_W'($urandom));
    end
    send_clear();
    send_byte(plain_byte());
    send_advance(plis_pkg::STEPS_W'($urandom));

    // Drain outstanding results, then watch for stray ones
    start <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
